FILE: hdl/sit_pkg.sv
package sit_pkg;

   localparam int unsigned TableDepthDefault = 64;
   localparam int unsigned EntryWidth = 50;
   localparam int unsigned OutCountWidth = 7;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd3;

   typedef struct packed {
      logic        command;
      logic [15:0] seq_id;
      logic [15:0] event_id;
      logic [7:0]  num_steps;
      logic        armed;
      logic        seq_type;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] hit_event_id;
      logic [7:0]  hit_num_steps;
      logic        hit_armed;
      logic        hit_type;
      logic [7:0]  hit_priority;
      logic [6:0]  entry_count;
      logic [6:0]  relative_count;
      logic [6:0]  absolute_count;
   } rsp_type;

   // stored layout: id, event, steps, armed, type, priority
   typedef struct packed {
      logic [15:0] key;
      logic [15:0] event_id;
      logic [7:0]  steps;
      logic        armed;
      logic        kind;
      logic [7:0]  prio;
   } entry_type;

endpackage

FILE: hdl/sit_ram.sv
module sit_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/sorted_id_table_insert_lookup.sv
// Sorted id table. A command is taken when start is high and busy low; one
// result word follows, shown for exactly one cycle with rsp_valid, and the
// receiver cannot stall it. All entries sit in one single-port-read memory
// with a registered read. A lookup is a binary search: each probe issues the
// read of the middle entry, then compares its key. An insert into a table
// that is not full searches the same way, then moves every later entry up
// one slot, reading each entry and then writing it one slot higher, and
// then writes the new entry. The memory needs no clearing: only the first
// held entries are ever read.
module sorted_id_table_insert_lookup
   import sit_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PROBE  = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_SHRD   = 3'd3;
   localparam logic [2:0] ST_SHWR   = 3'd4;
   localparam logic [2:0] ST_PLACE  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0] cnt_ff, cnt_in, rel_ff, rel_in, abs_ff, abs_in;
   logic [CW-1:0] sh_ff, sh_in;
   rsp_type     rsp_ff, rsp_in;
   logic        vld_ff, vld_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EntryWidth-1:0] wr_data, rd_raw;
   entry_type     rd_ent, new_ent;
   logic [CW:0]   mid_sum;

   sit_ram #(.WIDTH(EntryWidth), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );

   assign rd_ent = entry_type'(rd_raw);
   assign new_ent = '{key: req_ff.seq_id, event_id: req_ff.event_id,
                      steps: req_ff.num_steps, armed: req_ff.armed,
                      kind: req_ff.seq_type, prio: req_ff.priority_req};
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      cnt_in = cnt_ff;
      rel_in = rel_ff;
      abs_in = abs_ff;
      sh_in = sh_ff;
      rsp_in = rsp_ff;
      vld_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = sh_ff[AW-1:0];
      wr_data = rd_raw;
      rd_addr = mid_ff[AW-1:0];
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               lo_in = '0;
               hi_in = cnt_ff;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (req_ff.command == CMD_INSERT && cnt_ff >= CW'(TABLE_DEPTH)) begin
               rsp_in = '0;
               rsp_in.status = STATUS_FULL;
               state_in = ST_DONE;
            end else if (lo_ff < hi_ff) begin
               mid_in = mid_sum[CW:1];
               rd_addr = mid_sum[AW:1];
               state_in = ST_CHECK;
            end else begin
               rsp_in = '0;
               if (req_ff.command == CMD_LOOKUP) begin
                  rsp_in.status = STATUS_NOT_FOUND;
                  state_in = ST_DONE;
               end else begin
                  sh_in = cnt_ff;
                  state_in = (cnt_ff > lo_ff) ? ST_SHRD : ST_PLACE;
               end
            end
         end
         ST_CHECK: begin
            if (rd_ent.key == req_ff.seq_id) begin
               rsp_in = '0;
               if (req_ff.command == CMD_LOOKUP) begin
                  rsp_in.status = STATUS_OK;
                  rsp_in.hit_event_id = rd_ent.event_id;
                  rsp_in.hit_num_steps = rd_ent.steps;
                  rsp_in.hit_armed = rd_ent.armed;
                  rsp_in.hit_type = rd_ent.kind;
                  rsp_in.hit_priority = rd_ent.prio;
               end else begin
                  rsp_in.status = STATUS_DUPLICATE;
               end
               state_in = ST_DONE;
            end else begin
               if (rd_ent.key < req_ff.seq_id) begin
                  lo_in = mid_ff + CW'(1);
               end else begin
                  hi_in = mid_ff;
               end
               state_in = ST_PROBE;
            end
         end
         ST_SHRD: begin
            // read entry sh-1, written to sh next cycle
            rd_addr = AW'(sh_ff - CW'(1));
            state_in = ST_SHWR;
         end
         ST_SHWR: begin
            wr_en = 1'b1;
            sh_in = sh_ff - CW'(1);
            state_in = (sh_ff - CW'(1) > lo_ff) ? ST_SHRD : ST_PLACE;
         end
         ST_PLACE: begin
            wr_en = 1'b1;
            wr_addr = lo_ff[AW-1:0];
            wr_data = new_ent;
            cnt_in = cnt_ff + CW'(1);
            if (req_ff.seq_type) begin
               abs_in = abs_ff + CW'(1);
            end else begin
               rel_in = rel_ff + CW'(1);
            end
            rsp_in = '0;
            rsp_in.status = STATUS_OK;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_in.entry_count = OutCountWidth'(cnt_ff);
            rsp_in.relative_count = OutCountWidth'(rel_ff);
            rsp_in.absolute_count = OutCountWidth'(abs_ff);
            vld_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rel_ff <= '0;
         abs_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rel_ff <= rel_in;
         abs_ff <= abs_in;
         vld_ff <= vld_in;
      end
      req_ff <= req_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      sh_ff <= sh_in;
      rsp_ff <= rsp_in;
   end
endmodule

FILE: test/tb_sorted_id_table_insert_lookup.sv
`timescale 1ns / 100ps

module tb_sorted_id_table_insert_lookup;
   import sit_pkg::*;

   localparam int unsigned Depth = 64;
   localparam int unsigned CycleLimit = 900000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   sorted_id_table_insert_lookup #(.TABLE_DEPTH(Depth)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // predictor copy of the table, sorted by key
   entry_type table_copy[$];
   int unsigned rel_held;
   int unsigned abs_held;

   req_type pending_words[$];
   rsp_type expected_rsp[$];
   int      error_count;
   int      cycle_count;
   logic [15:0] used_ids[$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type predict_table(req_type w);
      rsp_type r;
      int lo, hi, mid, pos;
      bit hit;
      entry_type e;
      r = '0;
      lo = 0;
      hi = table_copy.size();
      hit = 1'b0;
      while (lo < hi && !hit) begin
         mid = lo + (hi - lo) / 2;
         if (table_copy[mid].key == w.seq_id) begin
            hit = 1'b1;
            lo = mid;
         end else if (table_copy[mid].key < w.seq_id) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      pos = lo;
      if (w.command == CMD_INSERT) begin
         if (table_copy.size() >= Depth) begin
            r.status = STATUS_FULL;
         end else if (hit) begin
            r.status = STATUS_DUPLICATE;
         end else begin
            e.key = w.seq_id;
            e.event_id = w.event_id;
            e.steps = w.num_steps;
            e.armed = w.armed;
            e.kind = w.seq_type;
            e.prio = w.priority_req;
            table_copy.insert(pos, e);
            if (w.seq_type) abs_held++;
            else rel_held++;
            r.status = STATUS_OK;
         end
      end else if (hit) begin
         r.status = STATUS_OK;
         r.hit_event_id = table_copy[pos].event_id;
         r.hit_num_steps = table_copy[pos].steps;
         r.hit_armed = table_copy[pos].armed;
         r.hit_type = table_copy[pos].kind;
         r.hit_priority = table_copy[pos].prio;
      end else begin
         r.status = STATUS_NOT_FOUND;
      end
      r.entry_count = 7'(table_copy.size());
      r.relative_count = 7'(rel_held);
      r.absolute_count = 7'(abs_held);
      return r;
   endfunction

   function automatic req_type make_word(logic cmd, logic [15:0] id);
      req_type w;
      w = req_type'($bits(req_type)'({$urandom, $urandom}));
      w.command = cmd;
      w.seq_id = id;
      return w;
   endfunction

   function automatic logic [15:0] pick_id();
      if (used_ids.size() > 0 && $urandom_range(0, 2) != 0)
         return used_ids[$urandom_range(0, used_ids.size() - 1)];
      return 16'($urandom);
   endfunction

   // driver: one word per handshake, random gap between words
   int idle_left;
   logic busy_seen;
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         idle_left <= 0;
      end else if (start && !busy_seen) begin
         start <= 1'b0;
         idle_left <= $urandom_range(0, 7);
      end else if (!start) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
         end else if (pending_words.size() > 0) begin
            req_data <= pending_words[0];
            start <= 1'b1;
         end
      end
   end

   // acceptance sampled at the rising edge
   always @(posedge clock) begin
      busy_seen <= busy;
      if (!reset && start && !busy) begin
         expected_rsp.push_back(predict_table(pending_words.pop_front()));
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            if (rsp_data !== expected_rsp[0]) begin
               $display("%0t: mismatch, expected %p, actual %p", $time,
                        expected_rsp[0], rsp_data);
               error_count++;
            end
            void'(expected_rsp.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [15:0] id;
      int n;
      error_count = 0;
      cycle_count = 0;
      rel_held = 0;
      abs_held = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed: empty lookup, extremes, duplicate, hits, misses
      pending_words.push_back(make_word(CMD_LOOKUP, 16'h0000));
      pending_words.push_back(make_word(CMD_INSERT, 16'hffff));
      pending_words.push_back(make_word(CMD_INSERT, 16'h0000));
      pending_words.push_back(make_word(CMD_INSERT, 16'h8000));
      pending_words.push_back(make_word(CMD_INSERT, 16'h8000));
      pending_words.push_back(make_word(CMD_LOOKUP, 16'hffff));
      pending_words.push_back(make_word(CMD_LOOKUP, 16'h0000));
      pending_words.push_back(make_word(CMD_LOOKUP, 16'h8000));
      pending_words.push_back(make_word(CMD_LOOKUP, 16'h7fff));
      pending_words.push_back(make_word(CMD_LOOKUP, 16'h0001));
      used_ids = '{16'h0000, 16'h8000, 16'hffff};
      // random: mixed inserts and lookups on new and reused ids
      n = 0;
      while (n < 1350) begin
         id = pick_id();
         if ($urandom_range(0, 1)) begin
            pending_words.push_back(make_word(CMD_INSERT, id));
            used_ids.push_back(id);
         end else begin
            pending_words.push_back(make_word(CMD_LOOKUP, id));
         end
         n++;
      end
      wait (pending_words.size() == 0 && expected_rsp.size() == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
